/* rtl/spae_pkg.sv */
// ----------------------------------------------------------------------------
// spae_pkg
// Shared types and constants for the slot pool with age eviction.
// ----------------------------------------------------------------------------
package spae_pkg;

  localparam int DefPoolSlots = 256;

  localparam logic [19:0] LifeTimeReset = 20'd10000;
  localparam logic [19:0] FadeTimeReset = 20'd1000;
  localparam logic [7:0]  FadeFull      = 8'd255;

  // Result status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_ACTIVE = 2'd1;
  localparam logic [1:0] ST_DISABLED   = 2'd2;
  localparam logic [1:0] ST_EMPTY      = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_LIFE   = 2'd1;
  localparam logic [1:0] REG_FADE   = 2'd2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_SWEEP = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_code_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DECODE, S_EV_RD, S_EV_CHK, S_REL_RD, S_REL_LINK,
    S_REL_FREE, S_AL_RD, S_AL_LINK, S_AL_NEWER, S_SW_RD, S_SW_CHK, S_DIV,
    S_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_INIT, OP_CAPTURE, OP_DECODE, OP_EV_RD, OP_EV_CHK,
    OP_REL_LINK, OP_REL_FREE, OP_AL_RD, OP_AL_LINK, OP_AL_NEWER,
    OP_SW_CHK, OP_DIV, OP_LOAD
  } op_t;

  typedef struct packed {
    cmd_code_t cmd;
    logic      en;
    logic      free_ok;
    logic      oldest_ok;
    logic      idx_ok;
    logic      tgt_ok;
    logic      ev_match;
    logic      evicting;
    logic      sw_expired;
    logic      sw_ramp;
    logic      div_done;
    logic      init_done;
    logic      out_free;
  } dp_status_t;

endpackage

/* rtl/spae_ctrl.sv */
// ----------------------------------------------------------------------------
// spae_ctrl
// Sequencer that steps the datapath through each transaction.
// ----------------------------------------------------------------------------
module spae_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  spae_pkg::dp_status_t st,
  output spae_pkg::op_t       op
);
  import spae_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT:     if (st.init_done) state_next = S_IDLE;
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        unique case (st.cmd)
          CMD_ALLOC: begin
            if (!st.en) state_next = S_FINISH;
            else if (st.free_ok) state_next = S_AL_RD;
            else if (st.oldest_ok) state_next = S_EV_RD;
            else state_next = S_FINISH;
          end
          CMD_FREE:  state_next = st.idx_ok ? S_REL_RD : S_FINISH;
          CMD_SWEEP: state_next = (st.en && st.tgt_ok) ? S_SW_RD : S_FINISH;
          default:   state_next = S_FINISH;
        endcase
      end
      S_EV_RD:    state_next = st.oldest_ok ? S_EV_CHK : S_AL_RD;
      S_EV_CHK:   state_next = st.ev_match ? S_REL_LINK : S_AL_RD;
      S_REL_RD:   state_next = S_REL_LINK;
      S_REL_LINK: state_next = S_REL_FREE;
      S_REL_FREE: state_next = st.evicting ? S_EV_RD : S_FINISH;
      S_AL_RD:    state_next = S_AL_LINK;
      S_AL_LINK:  state_next = S_AL_NEWER;
      S_AL_NEWER: state_next = S_FINISH;
      S_SW_RD:    state_next = S_SW_CHK;
      S_SW_CHK: begin
        if (st.sw_expired) state_next = S_REL_LINK;
        else if (st.sw_ramp) state_next = S_DIV;
        else state_next = S_FINISH;
      end
      S_DIV:      if (st.div_done) state_next = S_FINISH;
      S_FINISH:   if (st.out_free) state_next = S_IDLE;
      default:    state_next = S_INIT;
    endcase
  end

  always_comb begin
    op       = OP_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_INIT:     op = OP_INIT;
      S_IDLE: begin
        in_ready = 1'b1;
        op       = in_valid ? OP_CAPTURE : OP_NONE;
      end
      S_DECODE:   op = OP_DECODE;
      S_EV_RD:    op = OP_EV_RD;
      S_EV_CHK:   op = OP_EV_CHK;
      S_REL_RD:   op = OP_NONE;
      S_REL_LINK: op = OP_REL_LINK;
      S_REL_FREE: op = OP_REL_FREE;
      S_AL_RD:    op = OP_AL_RD;
      S_AL_LINK:  op = OP_AL_LINK;
      S_AL_NEWER: op = OP_AL_NEWER;
      S_SW_RD:    op = OP_NONE;
      S_SW_CHK:   op = OP_SW_CHK;
      S_DIV:      op = OP_DIV;
      S_FINISH:   op = OP_LOAD;
      default:    op = OP_NONE;
    endcase
  end

endmodule

/* rtl/spae_dpath.sv */
// ----------------------------------------------------------------------------
// spae_dpath
// Link memories, entry store, list pointers, fade divider and result register.
// ----------------------------------------------------------------------------
module spae_dpath #(
  parameter int POOL_SLOTS = spae_pkg::DefPoolSlots
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spae_pkg::op_t        op,
  output spae_pkg::dp_status_t st,
  input  logic                 cfg_enable,
  input  logic [19:0]          life_time,
  input  logic [19:0]          fade_time,
  input  logic [1:0]           command,
  input  logic [30:0]          now,
  input  logic [7:0]           slot_index,
  input  logic                 fade_alpha,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           slot,
  output logic [1:0]           status,
  output logic [8:0]           evicted_count,
  output logic                 expired,
  output logic [7:0]           fade_level,
  output logic                 alpha_mode,
  output logic                 last
);
  import spae_pkg::*;

  localparam int IW = $clog2(POOL_SLOTS);
  localparam int LW = $clog2(POOL_SLOTS + 1);
  localparam logic [LW-1:0] NoSlot = LW'(POOL_SLOTS);

  function automatic logic ok(input logic [LW-1:0] x);
    return x < NoSlot;
  endfunction

  function automatic logic [7:0] low8(input logic [LW-1:0] x);
    logic [LW+7:0] t;
    t = {8'b0, x};
    return t[7:0];
  endfunction

  function automatic logic [8:0] low9(input logic [LW-1:0] x);
    logic [LW+8:0] t;
    t = {9'b0, x};
    return t[8:0];
  endfunction

  logic [LW-1:0] nl_mem [POOL_SLOTS];
  logic [LW-1:0] ol_mem [POOL_SLOTS];
  logic [30:0]   time_mem [POOL_SLOTS];
  logic          mode_mem [POOL_SLOTS];
  logic [LW-1:0] nl_q, ol_q;
  logic [30:0]   time_q;
  logic          mode_q;

  logic [POOL_SLOTS-1:0] active;
  logic [IW-1:0] init_cnt;
  logic [LW-1:0] free_head, newest, oldest, cursor, rs, rn, ev_cnt;
  logic [30:0]   stamp;
  logic          evicting, ev_first;
  cmd_code_t     req_cmd;
  logic [30:0]   req_now;
  logic [7:0]    req_idx;
  logic          req_mode;
  logic [2:0]    div_cnt;
  logic [27:0]   div_num;

  logic [7:0] res_slot, res_fade;
  logic [1:0] res_status;
  logic       res_expired, res_amode, res_last;

  logic [IW-1:0] raddr;
  logic          nl_we, ol_we, ent_we;
  logic [IW-1:0] nl_wa, ol_wa, ent_wa;
  logic [LW-1:0] nl_wd, ol_wd;

  logic [LW+7:0] idx_wide;
  logic [LW-1:0] idx_ext, tgt;
  logic          idx_valid;
  logic [31:0]   sw_end, sw_t;
  logic [28:0]   div_sub;
  logic [27:0]   ramp_num;
  logic [1:0]    dec_status;
  logic          load_out;

  assign idx_wide  = {{LW{1'b0}}, req_idx};
  assign idx_ext   = idx_wide[LW-1:0];
  assign idx_valid = 32'(req_idx) < 32'(POOL_SLOTS);
  assign tgt       = ok(cursor) ? cursor : newest;

  assign sw_end   = {1'b0, time_q} + {12'b0, life_time};
  assign sw_t     = sw_end - {1'b0, req_now};
  assign ramp_num = {sw_t[19:0], 8'b0} - {8'b0, sw_t[19:0]};
  assign div_sub  = {1'b0, div_num} - ({9'b0, fade_time} << div_cnt);
  assign load_out = (op == OP_LOAD) && (!out_valid || out_ready);

  always_comb begin
    st.cmd        = req_cmd;
    st.en         = cfg_enable;
    st.free_ok    = ok(free_head);
    st.oldest_ok  = ok(oldest);
    st.idx_ok     = idx_valid && active[idx_ext[IW-1:0]];
    st.tgt_ok     = ok(tgt) && active[tgt[IW-1:0]];
    st.ev_match   = ev_first || (time_q == stamp);
    st.evicting   = evicting;
    st.sw_expired = {1'b0, req_now} > sw_end;
    st.sw_ramp    = sw_t < {12'b0, fade_time};
    st.div_done   = div_cnt == 3'd0;
    st.init_done  = init_cnt == IW'(POOL_SLOTS - 1);
    st.out_free   = !out_valid || out_ready;
  end

  // Status of the captured command as seen at decode.
  always_comb begin
    unique case (req_cmd)
      CMD_ALLOC: begin
        if (!cfg_enable) dec_status = ST_DISABLED;
        else if (!ok(free_head) && !ok(oldest)) dec_status = ST_EMPTY;
        else dec_status = ST_OK;
      end
      CMD_FREE:  dec_status = st.idx_ok ? ST_OK : ST_NOT_ACTIVE;
      CMD_SWEEP: begin
        if (!cfg_enable) dec_status = ST_DISABLED;
        else if (!st.tgt_ok) dec_status = ST_EMPTY;
        else dec_status = ST_OK;
      end
      default:   dec_status = ST_DISABLED;
    endcase
  end

  // Read address and write ports.
  always_comb begin
    raddr  = rs[IW-1:0];
    nl_we  = 1'b0;
    ol_we  = 1'b0;
    ent_we = 1'b0;
    nl_wa  = rs[IW-1:0];
    ol_wa  = rs[IW-1:0];
    ent_wa = free_head[IW-1:0];
    nl_wd  = NoSlot;
    ol_wd  = free_head;
    case (op)
      OP_INIT: begin
        nl_we = 1'b1;
        ol_we = 1'b1;
        nl_wa = init_cnt;
        ol_wa = init_cnt;
        ol_wd = LW'(init_cnt) + LW'(1);
      end
      OP_EV_RD: raddr = oldest[IW-1:0];
      OP_AL_RD: raddr = free_head[IW-1:0];
      OP_REL_LINK: begin
        ol_we = ok(nl_q);
        ol_wa = nl_q[IW-1:0];
        ol_wd = ol_q;
        nl_we = ok(ol_q);
        nl_wa = ol_q[IW-1:0];
        nl_wd = nl_q;
      end
      OP_REL_FREE: begin
        nl_we = 1'b1;
        ol_we = 1'b1;
      end
      OP_AL_LINK: begin
        nl_we  = 1'b1;
        ol_we  = 1'b1;
        ent_we = 1'b1;
        nl_wa  = free_head[IW-1:0];
        ol_wa  = free_head[IW-1:0];
        ol_wd  = newest;
      end
      OP_AL_NEWER: begin
        nl_we = ok(rn);
        nl_wa = rn[IW-1:0];
        nl_wd = rs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nl_we) nl_mem[nl_wa] <= nl_wd;
    if (ol_we) ol_mem[ol_wa] <= ol_wd;
    if (ent_we) begin
      time_mem[ent_wa] <= req_now;
      mode_mem[ent_wa] <= req_mode;
    end
    nl_q   <= nl_mem[raddr];
    ol_q   <= ol_mem[raddr];
    time_q <= time_mem[raddr];
    mode_q <= mode_mem[raddr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_CAPTURE: begin
        req_cmd  <= cmd_code_t'(command);
        req_now  <= now;
        req_idx  <= slot_index;
        req_mode <= fade_alpha;
      end
      OP_DECODE: begin
        res_slot    <= (req_cmd == CMD_FREE) ? req_idx : 8'd0;
        res_status  <= dec_status;
        res_expired <= 1'b0;
        res_fade    <= 8'd0;
        res_amode   <= 1'b0;
        res_last    <= (req_cmd == CMD_SWEEP) && cfg_enable && !st.tgt_ok;
        ev_cnt      <= '0;
        ev_first    <= 1'b1;
        if (req_cmd == CMD_FREE) rs <= idx_ext;
        else if (req_cmd == CMD_SWEEP) rs <= tgt;
      end
      OP_EV_RD: rs <= oldest;
      OP_EV_CHK: begin
        ev_first <= 1'b0;
        if (ev_first) stamp <= time_q;
        if (ev_first || time_q == stamp) ev_cnt <= ev_cnt + LW'(1);
      end
      OP_AL_LINK: begin
        rs        <= free_head;
        rn        <= newest;
        res_slot  <= low8(free_head);
        res_amode <= req_mode;
      end
      OP_SW_CHK: begin
        res_slot  <= low8(rs);
        res_amode <= mode_q;
        res_last  <= !ok(ol_q);
        div_cnt   <= 3'd7;
        div_num   <= ramp_num;
        if ({1'b0, req_now} > sw_end) res_expired <= 1'b1;
        else if (!(sw_t < {12'b0, fade_time})) res_fade <= FadeFull;
      end
      OP_DIV: begin
        div_cnt <= div_cnt - 3'd1;
        if (!div_sub[28]) begin
          div_num           <= div_sub[27:0];
          res_fade[div_cnt] <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // List pointers and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt  <= '0;
      active    <= '0;
      free_head <= '0;
      newest    <= NoSlot;
      oldest    <= NoSlot;
      cursor    <= NoSlot;
      evicting  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (op)
        OP_INIT: init_cnt <= init_cnt + IW'(1);
        OP_DECODE: begin
          evicting <= (req_cmd == CMD_ALLOC) && cfg_enable && !ok(free_head)
                      && ok(oldest);
          if (req_cmd == CMD_SWEEP && cfg_enable
              && !(ok(tgt) && active[tgt[IW-1:0]])) cursor <= NoSlot;
        end
        OP_EV_RD: if (!ok(oldest)) evicting <= 1'b0;
        OP_EV_CHK: if (!(ev_first || time_q == stamp)) evicting <= 1'b0;
        OP_REL_LINK: begin
          if (!ok(nl_q)) newest <= ol_q;
          if (!ok(ol_q)) oldest <= nl_q;
          if (cursor == rs) cursor <= ok(ol_q) ? ol_q : NoSlot;
          active[rs[IW-1:0]] <= 1'b0;
        end
        OP_REL_FREE: free_head <= rs;
        OP_AL_LINK: begin
          free_head <= ol_q;
          active[free_head[IW-1:0]] <= 1'b1;
          newest <= free_head;
          if (!ok(newest)) oldest <= free_head;
        end
        OP_SW_CHK: cursor <= ok(ol_q) ? ol_q : NoSlot;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      slot          <= res_slot;
      status        <= res_status;
      evicted_count <= low9(ev_cnt);
      expired       <= res_expired;
      fade_level    <= res_fade;
      alpha_mode    <= res_amode;
      last          <= res_last;
    end
  end

endmodule

/* rtl/slot_pool_with_age_eviction.sv */
// ----------------------------------------------------------------------------
// slot_pool_with_age_eviction
// Slot allocator with a LIFO free list and an age-ordered active list.
// ----------------------------------------------------------------------------
// Alloc takes longer for each evicted entry; sweep runs the fade divider when the
// entry is in its fade ramp and frees the entry when it has expired. A held result
// stalls the next accept. One transaction is in work at a time. After reset an
// init pass over every slot chains the free list.
// ----------------------------------------------------------------------------
module slot_pool_with_age_eviction #(
  parameter int POOL_SLOTS = spae_pkg::DefPoolSlots
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [30:0] now,
  input  logic [7:0]  slot_index,
  input  logic        fade_alpha,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  slot,
  output logic [1:0]  status,
  output logic [8:0]  evicted_count,
  output logic        expired,
  output logic [7:0]  fade_level,
  output logic        alpha_mode,
  output logic        last
);
  import spae_pkg::*;

  // Configuration registers. They are to be written only while the block is idle (the
  // block itself does not enforce this), so the datapath reads them directly.
  logic        marks_enable;
  logic [19:0] life_time;
  logic [19:0] fade_time;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks_enable <= 1'b1;
      life_time    <= LifeTimeReset;
      fade_time    <= FadeTimeReset;
    end else if (wr_en && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        REG_ENABLE: marks_enable <= pwdata[0];
        REG_LIFE:   life_time    <= pwdata[19:0];
        REG_FADE:   fade_time    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr[3:2])
      REG_ENABLE: prdata = {31'd0, marks_enable};
      REG_LIFE:   prdata = {12'd0, life_time};
      REG_FADE:   prdata = {12'd0, fade_time};
      default:    prdata = 32'd0;
    endcase
  end

  // The controller walks each transaction through its micro-steps; the
  // datapath holds the lists and answers with status flags.
  op_t        op;
  dp_status_t st;

  spae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .op       (op)
  );

  spae_dpath #(.POOL_SLOTS(POOL_SLOTS)) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .st            (st),
    .cfg_enable    (marks_enable),
    .life_time     (life_time),
    .fade_time     (fade_time),
    .command       (command),
    .now           (now),
    .slot_index    (slot_index),
    .fade_alpha    (fade_alpha),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .slot          (slot),
    .status        (status),
    .evicted_count (evicted_count),
    .expired       (expired),
    .fade_level    (fade_level),
    .alpha_mode    (alpha_mode),
    .last          (last)
  );

endmodule

/* rtl/spae_checker.sv */
// ----------------------------------------------------------------------------
// spae_checker
// Port-level checks on results of the slot pool.
// ----------------------------------------------------------------------------
module spae_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] slot,
  input logic [1:0] status,
  input logic [8:0] evicted_count,
  input logic       expired,
  input logic [7:0] fade_level
);
  import spae_pkg::*;

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> slot == 8'd0 && !expired && fade_level == 8'd0)
    else $error("empty result carries data");

  a_expired_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && expired |-> fade_level == 8'd0 && status == ST_OK
                             && evicted_count == 9'd0)
    else $error("expired entry with fade or error");

  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_count != 9'd0 |-> status == ST_OK)
    else $error("eviction without successful alloc");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(status))
    else $error("stalled result changed");

endmodule

bind slot_pool_with_age_eviction spae_checker u_spae_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .slot          (slot),
  .status        (status),
  .evicted_count (evicted_count),
  .expired       (expired),
  .fade_level    (fade_level)
);
